@@ rtl/core/imsi_tbcd_packet_decoder_defines.svh @@
// assertion macros for the imsi tbcd packet decoder
`ifndef IMSI_TBCD_PACKET_DECODER_DEFINES_SVH
`define IMSI_TBCD_PACKET_DECODER_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define IMSI_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("imsi tbcd decoder: same-cycle check failed");

// next-cycle implication, held off while reset is low
`define IMSI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("imsi tbcd decoder: next-cycle check failed");

`endif

@@ rtl/core/imsi_tbcd_pkg.sv @@
// shared types and constants for the imsi tbcd packet decoder
package imsi_tbcd_pkg;

    localparam int DEF_HEADER_BYTES     = 4;
    localparam int DEF_IMSI_DIGITS      = 15;
    localparam int DEF_MIN_PACKET_BYTES = 8;

    localparam int IMSI_W = 60;
    localparam int POS_W  = 4;

    localparam logic [3:0]       NIBBLE_FILLER = 4'hF;
    localparam logic [3:0]       MAX_DIGIT     = 4'd9;
    localparam logic [POS_W-1:0] POS_MAX       = 4'd15;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_BAD_DIGIT = 2'd2,
        STATUS_BAD_COUNT = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [IMSI_W-1:0] imsi_digits;
        status_t           status;
    } out_item_t;

endpackage

@@ rtl/core/imsi_tbcd_packet_decoder.sv @@
// a request byte is taken into the input register; the result of a final byte then goes to the result register
// throughput: one byte per cycle; a final byte waits in the input register
// only while the result register holds an untaken result
// reset: aresetn synchronous active low, clears the input and result
// valid flags and the per-packet position, count, store and error state
`include "imsi_tbcd_packet_decoder_defines.svh"

module imsi_tbcd_packet_decoder #(
    parameter int HEADER_BYTES     = imsi_tbcd_pkg::DEF_HEADER_BYTES,
    parameter int IMSI_DIGITS      = imsi_tbcd_pkg::DEF_IMSI_DIGITS,
    parameter int MIN_PACKET_BYTES = imsi_tbcd_pkg::DEF_MIN_PACKET_BYTES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  imsi_tbcd_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output imsi_tbcd_pkg::out_item_t  m_item
);

    logic                      stage_valid_reg;
    imsi_tbcd_pkg::in_item_t   stage_item_reg;
    logic                      m_valid_reg;
    imsi_tbcd_pkg::out_item_t  m_item_reg;
    imsi_tbcd_pkg::out_item_t  result;
    logic                      stage_adv;

    // only a final byte needs room in the result register
    assign stage_adv = stage_valid_reg &&
                       (!stage_item_reg.last_byte || !m_valid_reg || m_ready);
    assign s_ready   = !stage_valid_reg || stage_adv;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    imsi_tbcd_collect #(
        .HEADER_BYTES     (HEADER_BYTES),
        .IMSI_DIGITS      (IMSI_DIGITS),
        .MIN_PACKET_BYTES (MIN_PACKET_BYTES)
    ) u_collect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (stage_adv),
        .item    (stage_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                stage_valid_reg <= 1'b1;
            end else if (stage_adv) begin
                stage_valid_reg <= 1'b0;
            end
            if (stage_adv && stage_item_reg.last_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_item_reg <= s_item;
        end
        if (stage_adv && stage_item_reg.last_byte) begin
            m_item_reg <= result;
        end
    end

    `IMSI_ASSERT_IMPLY(a_digits_zero_on_reject, aclk, aresetn,
        m_valid_reg && m_item_reg.status != imsi_tbcd_pkg::STATUS_OK,
        m_item_reg.imsi_digits == '0)
    `IMSI_ASSERT_NEXT(a_stage_holds_on_stall, aclk, aresetn,
        stage_valid_reg && !stage_adv,
        stage_valid_reg && $stable(stage_item_reg))
    `IMSI_ASSERT_NEXT(a_no_result_midpacket, aclk, aresetn,
        stage_adv && !stage_item_reg.last_byte && (!m_valid_reg || m_ready),
        !m_valid_reg)

endmodule

@@ rtl/core/imsi_tbcd_collect.sv @@
// per-packet digit collection state and result formation for one byte
module imsi_tbcd_collect #(
    parameter int HEADER_BYTES     = imsi_tbcd_pkg::DEF_HEADER_BYTES,
    parameter int IMSI_DIGITS      = imsi_tbcd_pkg::DEF_IMSI_DIGITS,
    parameter int MIN_PACKET_BYTES = imsi_tbcd_pkg::DEF_MIN_PACKET_BYTES
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  imsi_tbcd_pkg::in_item_t item,
    output imsi_tbcd_pkg::out_item_t result
);

    localparam int STORE_W = 4 * IMSI_DIGITS;
    localparam int CNT_W   = $clog2(IMSI_DIGITS + 1);
    localparam int POS_W   = imsi_tbcd_pkg::POS_W;

    localparam logic [POS_W-1:0] HEADER_C = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] MIN_C    = POS_W'(MIN_PACKET_BYTES);
    localparam logic [CNT_W:0]   DIGITS_C = (CNT_W + 1)'(IMSI_DIGITS);

    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [STORE_W-1:0] store_reg, store_next;
    logic               err_reg,   err_next;

    logic [3:0]         lo_nib;
    logic [3:0]         hi_nib;
    logic [CNT_W:0]     cnt_lo;
    logic [STORE_W-1:0] store_lo;
    logic               blocked;

    assign lo_nib   = item.data_byte[3:0];
    assign hi_nib   = item.data_byte[7:4];
    assign cnt_lo   = {1'b0, cnt_reg} + (CNT_W + 1)'(1);
    assign store_lo = STORE_W'({store_reg, lo_nib});
    assign blocked  = err_reg || ({1'b0, cnt_reg} >= DIGITS_C);

    always_comb begin
        cnt_next   = cnt_reg;
        store_next = store_reg;
        err_next   = err_reg;
        pos_next   = (pos_reg == imsi_tbcd_pkg::POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

        if (pos_reg >= HEADER_C && !blocked) begin
            if (lo_nib > imsi_tbcd_pkg::MAX_DIGIT) begin
                err_next = 1'b1;
            end else begin
                store_next = store_lo;
                cnt_next   = cnt_lo[CNT_W-1:0];
                // high nibble is dropped once the count is full or as final filler
                if (cnt_lo >= DIGITS_C) begin
                    cnt_next = cnt_lo[CNT_W-1:0];
                end else if (hi_nib == imsi_tbcd_pkg::NIBBLE_FILLER && item.last_byte) begin
                    cnt_next = cnt_lo[CNT_W-1:0];
                end else if (hi_nib > imsi_tbcd_pkg::MAX_DIGIT) begin
                    err_next = 1'b1;
                end else begin
                    store_next = STORE_W'({store_lo, hi_nib});
                    cnt_next   = cnt_reg + CNT_W'(2);
                end
            end
        end
    end

    always_comb begin
        result.imsi_digits = '0;
        if (pos_next < MIN_C) begin
            result.status = imsi_tbcd_pkg::STATUS_SHORT;
        end else if (err_next) begin
            result.status = imsi_tbcd_pkg::STATUS_BAD_DIGIT;
        end else if ({1'b0, cnt_next} != DIGITS_C) begin
            result.status = imsi_tbcd_pkg::STATUS_BAD_COUNT;
        end else begin
            result.status      = imsi_tbcd_pkg::STATUS_OK;
            result.imsi_digits = imsi_tbcd_pkg::IMSI_W'(store_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            cnt_reg   <= '0;
            store_reg <= '0;
            err_reg   <= 1'b0;
        end else if (step) begin
            if (item.last_byte) begin
                pos_reg   <= '0;
                cnt_reg   <= '0;
                store_reg <= '0;
                err_reg   <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                cnt_reg   <= cnt_next;
                store_reg <= store_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

@@ tb/sv/imsi_tbcd_packet_decoder_checker.sv @@
// checker for the imsi tbcd packet decoder: predicts each packet verdict and compares results
`timescale 1ns / 100ps

module imsi_tbcd_packet_decoder_checker
    import imsi_tbcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        fail_count,
    output int        pending,
    output int        results_seen,
    output int        imsi_accepted
);

    // predicted per-packet state
    logic [POS_W-1:0]  byte_pos;
    int                digit_cnt;
    logic [IMSI_W-1:0] digit_acc;
    logic              digit_bad;

    out_item_t imsi_due[$];

    task automatic clear_packet();
        byte_pos  = '0;
        digit_cnt = 0;
        digit_acc = '0;
        digit_bad = 1'b0;
    endtask

    task automatic take_nibble(input logic [3:0] nib);
        if (nib > MAX_DIGIT) begin
            digit_bad = 1'b1;
        end else begin
            digit_acc = {digit_acc[IMSI_W-5:0], nib};
            digit_cnt++;
        end
    endtask

    task automatic decode_packet_byte(input in_item_t req);
        logic [3:0] lo;
        logic [3:0] hi;
        out_item_t  verdict;
        lo = req.data_byte[3:0];
        hi = req.data_byte[7:4];
        if (byte_pos >= DEF_HEADER_BYTES && !digit_bad && digit_cnt < DEF_IMSI_DIGITS) begin
            take_nibble(lo);
            // high nibble skipped once the count is full, or as filler on the final byte
            if (!digit_bad && digit_cnt < DEF_IMSI_DIGITS
                    && !(hi == NIBBLE_FILLER && req.last_byte))
                take_nibble(hi);
        end
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + 1'b1;
        if (req.last_byte) begin
            verdict.imsi_digits = '0;
            if (byte_pos < DEF_MIN_PACKET_BYTES) begin
                verdict.status = STATUS_SHORT;
            end else if (digit_bad) begin
                verdict.status = STATUS_BAD_DIGIT;
            end else if (digit_cnt != DEF_IMSI_DIGITS) begin
                verdict.status = STATUS_BAD_COUNT;
            end else begin
                verdict.status      = STATUS_OK;
                verdict.imsi_digits = digit_acc;
            end
            imsi_due = {imsi_due, verdict};
            clear_packet();
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_packet();
            imsi_due.delete();
            fail_count    <= 0;
            results_seen  <= 0;
            imsi_accepted <= 0;
        end else begin
            if (s_valid && s_ready)
                decode_packet_byte(s_item);
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (imsi_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: digits %h status %0d",
                                 m_item.imsi_digits, m_item.status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = imsi_due.pop_front();
                    if (want.status == STATUS_OK)
                        imsi_accepted <= imsi_accepted + 1;
                    if (m_item.imsi_digits !== want.imsi_digits
                            || m_item.status !== want.status) begin
                        if (fail_count < 10)
                            $display({"mismatch on result %0d: expected digits %h status %0d,",
                                      " got digits %h status %0d"},
                                     results_seen, want.imsi_digits, want.status,
                                     m_item.imsi_digits, m_item.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= imsi_due.size();
    end

endmodule

@@ tb/sv/imsi_tbcd_packet_decoder_test.sv @@
// top of the imsi tbcd packet decoder testbench: packet stimulus, flow control and verdict
`timescale 1ns / 100ps

module imsi_tbcd_packet_decoder_test;
    import imsi_tbcd_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int BYTES_PER_PHASE = 130;

    typedef enum int {
        PK_FILLER,
        PK_SIXTEEN,
        PK_TAIL,
        PK_BAD,
        PK_FEW,
        PK_MIDFILL,
        PK_SHORT,
        PK_NOISE
    } pkt_kind_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int fail_count;
    int pending;
    int results_seen;
    int imsi_accepted;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;
    int packets   = 0;
    int bytes_sent = 0;

    in_item_t burst[$];

    imsi_tbcd_packet_decoder uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    imsi_tbcd_packet_decoder_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .imsi_accepted (imsi_accepted)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] digit_pair();
        return {4'($urandom_range(9)), 4'($urandom_range(9))};
    endfunction

    task automatic add_byte(input logic [7:0] b);
        in_item_t req;
        req.data_byte = b;
        req.last_byte = 1'b0;
        burst = {burst, req};
    endtask

    task automatic build_packet(input pkt_kind_t kind);
        int         n_full;
        int         at;
        logic [7:0] b;
        burst.delete();
        if (kind == PK_SHORT || kind == PK_NOISE) begin
            n_full = (kind == PK_SHORT) ? $urandom_range(1, 7) : $urandom_range(1, 20);
            repeat (n_full) add_byte(8'($urandom));
        end else begin
            repeat (DEF_HEADER_BYTES) add_byte(8'($urandom));
            n_full = (kind == PK_FEW) ? $urandom_range(2, 6) : 7;
            repeat (n_full) add_byte(digit_pair());
            b = digit_pair();
            case (kind)
                PK_SIXTEEN: b[7:4] = 4'($urandom_range(15));
                PK_TAIL:    b = digit_pair();
                PK_FEW:     if ($urandom_range(1)) b[7:4] = NIBBLE_FILLER;
                default:    b[7:4] = NIBBLE_FILLER;
            endcase
            add_byte(b);
            // bytes past the digit limit, any value
            if (kind == PK_TAIL)
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
            if (kind == PK_BAD) begin
                at = $urandom_range(DEF_HEADER_BYTES, burst.size() - 1);
                b = burst[at].data_byte;
                if ($urandom_range(1))
                    b[3:0] = 4'($urandom_range(10, 15));
                else
                    b[7:4] = 4'($urandom_range(10, 15));
                burst[at].data_byte = b;
            end
            // filler in a byte that is not the final one
            if (kind == PK_MIDFILL) begin
                at = $urandom_range(DEF_HEADER_BYTES, burst.size() - 2);
                b = burst[at].data_byte;
                b[7:4] = NIBBLE_FILLER;
                burst[at].data_byte = b;
            end
        end
        burst[burst.size() - 1].last_byte = 1'b1;
    endtask

    task automatic send_request(input in_item_t req);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_burst();
        foreach (burst[i])
            send_request(burst[i]);
        packets++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic send_fixed(input logic [7:0] bytes[$]);
        burst.delete();
        foreach (bytes[i])
            add_byte(bytes[i]);
        burst[burst.size() - 1].last_byte = 1'b1;
        send_burst();
    endtask

    initial begin
        int        phase_start;
        int        pick;
        pkt_kind_t kind;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-byte packet, then a too-short packet that also holds a bad digit
        send_fixed('{8'hFF});
        send_fixed('{8'h00, 8'h00, 8'h00, 8'h00, 8'hAB, 8'h99, 8'h00});
        // full imsi of extreme digits with filler in the final byte
        send_fixed('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h90, 8'h09, 8'h99, 8'h00,
                     8'h99, 8'h90, 8'h09, 8'hF9});
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 30)      kind = PK_FILLER;
                else if (pick < 42) kind = PK_SIXTEEN;
                else if (pick < 52) kind = PK_TAIL;
                else if (pick < 64) kind = PK_BAD;
                else if (pick < 74) kind = PK_FEW;
                else if (pick < 82) kind = PK_MIDFILL;
                else if (pick < 91) kind = PK_SHORT;
                else                kind = PK_NOISE;
                build_packet(kind);
                send_burst();
            end
            // hold the sender until every verdict of this phase is back
            drain();
        end

        repeat (10) @(posedge aclk);
        $display("%0d packets, %0d request bytes, %0d verdicts of which %0d accepted imsis",
                 packets, bytes_sent, results_seen, imsi_accepted);
        $display("flow control mixes: free running, sender gaps, receiver stalls, both");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
